>>> rtl/fbfl_pkg.sv
`timescale 1ns / 1ps

package fbfl_pkg;

    localparam int BLOCK_COUNT_W = 11;
    localparam int BLOCK_SIZE_W  = 17;
    localparam int OFFSET_W      = 26;
    localparam int STATUS_W      = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 17;

    localparam int DEF_MAX_BLOCKS = 1024;

    localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
    localparam logic [BLOCK_SIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd256;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_BAD   = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;

endpackage

>>> rtl/fbfl_ram.sv
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/fixed_block_free_list_allocator_top.sv
`timescale 1ns / 1ps

// Fixed-block allocator: a LIFO stack of free block indices in one RAM. An
// allocate (action 0) pops the top index and returns index * block_size
// through a RAM read, then one multiply. A free (action 1) divides the
// offset by block_size with a restoring divider that makes one quotient bit a
// cycle, checks alignment, range and fullness, then pushes. The block takes
// one item at a time and drops ready while busy or while a configuration
// write is offered; the result waits in an output register. A write to
// either configuration register restarts the stack full, indices
// min(block_count, MAX_BLOCKS)-1 .. 0 with 0 on top, at once: entries never
// written since are produced from a low-water mark, so no clearing pass runs.
module fixed_block_free_list_allocator_top #(
    parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_action,
    input  logic [fbfl_pkg::OFFSET_W-1:0]    s_free_offset,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fbfl_pkg::STATUS_W-1:0]    m_status,
    output logic [fbfl_pkg::OFFSET_W-1:0]    m_alloc_offset,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbfl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import fbfl_pkg::*;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int EXT_W  = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;
    localparam int PROD_W = (IDX_W + BLOCK_SIZE_W > OFFSET_W) ?
                            (IDX_W + BLOCK_SIZE_W) : OFFSET_W;
    localparam int DCNT_W = $clog2(OFFSET_W);
    localparam int REM_W  = BLOCK_SIZE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(OFFSET_W - 1);

    function automatic logic [CNT_W-1:0] eff_count(input logic [BLOCK_COUNT_W-1:0] bc);
        logic [EXT_W-1:0] bc_ext;
        logic [EXT_W-1:0] max_ext;
        logic [EXT_W-1:0] sel;
        bc_ext  = EXT_W'(bc);
        max_ext = EXT_W'(MAX_BLOCKS);
        sel     = (bc_ext > max_ext) ? max_ext : bc_ext;
        return sel[CNT_W-1:0];
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [BLOCK_COUNT_W-1:0] block_count_reg, block_count_next;
    logic [BLOCK_SIZE_W-1:0]  block_size_reg, block_size_next;
    logic [CNT_W-1:0]         free_count_reg, free_count_next;
    logic [CNT_W-1:0]         low_mark_reg, low_mark_next;
    logic                     m_valid_reg, m_valid_next;

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     orig_reg, orig_next;
    logic [OFFSET_W-1:0]      quo_reg, quo_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;
    status_t                  status_reg, status_next;
    logic [OFFSET_W-1:0]      res_reg, res_next;
    status_t                  m_status_reg, m_status_next;
    logic [OFFSET_W-1:0]      m_offset_reg, m_offset_next;

    logic [CNT_W-1:0]         n_cnt;
    logic [CNT_W-1:0]         fc_m1;
    logic [IDX_W-1:0]         idx_sel;
    logic [PROD_W-1:0]        prod;
    logic [REM_W:0]           rem_sh;
    logic [REM_W+1:0]         diff;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [IDX_W-1:0]         ram_wdata;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [IDX_W-1:0]         ram_rdata;

    fbfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS),
        .ADDR_W(IDX_W)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready        = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready      = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_offset = m_offset_reg;

    assign n_cnt   = eff_count(block_count_reg);
    assign fc_m1   = free_count_reg - CNT_W'(1);
    assign idx_sel = orig_reg ? idx_reg : ram_rdata;
    assign prod    = PROD_W'(idx_sel) * PROD_W'(block_size_reg);
    assign rem_sh  = {rem_reg, quo_reg[OFFSET_W-1]};
    assign diff    = {1'b0, rem_sh} - (REM_W + 2)'(block_size_reg);

    always_comb begin
        state_next       = state_reg;
        block_count_next = block_count_reg;
        block_size_next  = block_size_reg;
        free_count_next  = free_count_reg;
        low_mark_next    = low_mark_reg;
        m_valid_next     = m_valid_reg;
        idx_next         = idx_reg;
        orig_next        = orig_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        dcnt_next        = dcnt_reg;
        status_next      = status_reg;
        res_next         = res_reg;
        m_status_next    = m_status_reg;
        m_offset_next    = m_offset_reg;
        ram_we           = 1'b0;
        ram_waddr        = free_count_reg[IDX_W-1:0];
        ram_wdata        = quo_reg[IDX_W-1:0];
        ram_re           = 1'b0;
        ram_raddr        = fc_m1[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    if (cfg_index == CFG_BLOCK_COUNT) begin
                        block_count_next = cfg_data[BLOCK_COUNT_W-1:0];
                        free_count_next  = eff_count(cfg_data[BLOCK_COUNT_W-1:0]);
                        low_mark_next    = eff_count(cfg_data[BLOCK_COUNT_W-1:0]);
                    end else if (cfg_index == CFG_BLOCK_SIZE) begin
                        block_size_next = cfg_data[BLOCK_SIZE_W-1:0];
                        free_count_next = n_cnt;
                        low_mark_next   = n_cnt;
                    end
                end else if (s_valid) begin
                    res_next = '0;
                    if (s_action == ACT_ALLOC) begin
                        if (free_count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end else begin
                            ram_re          = 1'b1;
                            orig_next       = (free_count_reg == low_mark_reg);
                            idx_next        = IDX_W'(n_cnt - free_count_reg);
                            free_count_next = fc_m1;
                            if (free_count_reg == low_mark_reg) begin
                                low_mark_next = fc_m1;
                            end
                            state_next = S_MUL;
                        end
                    end else begin
                        if (block_size_reg == '0) begin
                            status_next = ST_BAD;
                            state_next  = S_FIN;
                        end else begin
                            quo_next   = s_free_offset;
                            rem_next   = '0;
                            dcnt_next  = '0;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_MUL: begin
                res_next    = prod[OFFSET_W-1:0];
                status_next = ST_OK;
                state_next  = S_FIN;
            end
            S_DIV: begin
                if (!diff[REM_W+1]) begin
                    rem_next = diff[REM_W-1:0];
                end else begin
                    rem_next = rem_sh[REM_W-1:0];
                end
                quo_next  = {quo_reg[OFFSET_W-2:0], ~diff[REM_W+1]};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DIV_LAST) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (rem_reg != '0 || quo_reg >= OFFSET_W'(n_cnt)) begin
                    status_next = ST_BAD;
                end else if (free_count_reg >= n_cnt) begin
                    status_next = ST_FULL;
                end else begin
                    ram_we          = 1'b1;
                    free_count_next = free_count_reg + CNT_W'(1);
                    status_next     = ST_OK;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_offset_next = res_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            block_count_reg <= BLOCK_COUNT_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
            free_count_reg  <= eff_count(BLOCK_COUNT_RST);
            low_mark_reg    <= eff_count(BLOCK_COUNT_RST);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            block_size_reg  <= block_size_next;
            free_count_reg  <= free_count_next;
            low_mark_reg    <= low_mark_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        orig_reg     <= orig_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

class allocator_scoreboard;
    bit [9:0]          stack [fbfl_pkg::DEF_MAX_BLOCKS];
    int unsigned       depth;
    int unsigned       count_reg;
    int unsigned       size_reg;
    fbfl_pkg::status_t expected_status [$];
    logic [25:0]       expected_offset [$];
    logic [25:0]       handed_out [$];
    int                errors;

    function new();
        count_reg = fbfl_pkg::BLOCK_COUNT_RST;
        size_reg  = fbfl_pkg::BLOCK_SIZE_RST;
        errors    = 0;
        refill();
    endfunction

    function int unsigned eff_count();
        return (count_reg > fbfl_pkg::DEF_MAX_BLOCKS) ? fbfl_pkg::DEF_MAX_BLOCKS : count_reg;
    endfunction

    function void refill();
        int unsigned n;
        n = eff_count();
        for (int unsigned i = 0; i < n; i++) stack[i] = 10'(n - 1 - i);
        depth = n;
        handed_out.delete();
    endfunction

    function int pending();
        return expected_status.size();
    endfunction

    function void configure(logic [fbfl_pkg::CFG_INDEX_W-1:0] idx,
                            logic [fbfl_pkg::CFG_DATA_W-1:0] data);
        if (idx == fbfl_pkg::CFG_BLOCK_COUNT) begin
            count_reg = data[10:0];
            refill();
        end else if (idx == fbfl_pkg::CFG_BLOCK_SIZE) begin
            size_reg = data;
            refill();
        end
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_request(logic act, logic [25:0] off);
        int unsigned       n;
        fbfl_pkg::status_t st;
        logic [25:0]       res;
        logic [63:0]       prod;
        n   = eff_count();
        res = '0;
        if (act == fbfl_pkg::ACT_ALLOC) begin
            if (depth == 0) begin
                st = fbfl_pkg::ST_EMPTY;
            end else begin
                depth--;
                prod = 64'(stack[depth]) * 64'(size_reg);
                res  = prod[25:0];
                st   = fbfl_pkg::ST_OK;
                handed_out.insert(handed_out.size(), res);
            end
        end else if (size_reg == 0 || (off % size_reg) != 0 || (off / size_reg) >= n) begin
            st = fbfl_pkg::ST_BAD;
        end else if (depth >= n) begin
            st = fbfl_pkg::ST_FULL;
        end else begin
            stack[depth] = 10'(off / size_reg);
            depth++;
            st = fbfl_pkg::ST_OK;
        end
        expected_status.insert(expected_status.size(), st);
        expected_offset.insert(expected_offset.size(), res);
    endfunction

    task check_response(fbfl_pkg::status_t st, logic [25:0] off);
        fbfl_pkg::status_t es;
        logic [25:0]       eo;
        if (expected_status.size() == 0) begin
            report($sformatf("result with nothing pending: status %0d offset %0h", st, off));
            return;
        end
        es = expected_status.pop_front();
        eo = expected_offset.pop_front();
        if (st !== es) report($sformatf("status %0d, expected %0d", st, es));
        if (off !== eo) report($sformatf("alloc_offset %0h, expected %0h", off, eo));
    endtask
endclass

module testbench;
    import fbfl_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd2;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_action       = ACT_ALLOC;
    logic [OFFSET_W-1:0]    s_free_offset  = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [OFFSET_W-1:0]    m_alloc_offset;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = CFG_BLOCK_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    int send_idle  = 0;
    int recv_stall = 0;

    allocator_scoreboard sb = new();

    fixed_block_free_list_allocator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_free_offset (s_free_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_alloc_offset(m_alloc_offset),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_response(m_status, m_alloc_offset);
            if (s_valid && s_ready) sb.note_request(s_action, s_free_offset);
            if (cfg_valid && cfg_ready) sb.configure(cfg_index, cfg_data);
        end
    end

    task automatic send_item(input logic act, input logic [OFFSET_W-1:0] off);
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_free_offset <= off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] cnt,
                              input logic [CFG_DATA_W-1:0] sz, input bit extra);
        wait_idle();
        write_reg(CFG_BLOCK_COUNT, cnt);
        write_reg(CFG_BLOCK_SIZE, sz);
        if (extra) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 84; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 84; end
            default: begin send_idle = 37; recv_stall = 37; end
        endcase
    endtask

    task automatic directed_items();
        send_item(ACT_ALLOC, '0);
        send_item(ACT_ALLOC, '1);
        send_item(ACT_FREE, 26'd256);
        send_item(ACT_FREE, 26'd0);
        send_item(ACT_FREE, 26'd0);
        send_item(ACT_FREE, 26'd1);
        send_item(ACT_FREE, 26'd262144);
        send_item(ACT_FREE, '1);
        set_config(17'd1, 17'd1, 1'b0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, 26'd0);
        send_item(ACT_FREE, 26'd0);
        send_item(ACT_FREE, 26'd1);
        set_config(17'd0, 17'd5, 1'b0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, 26'd0);
        set_config(17'd2, 17'd0, 1'b0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, 26'd0);
        set_config(17'd2047, 17'd65536, 1'b0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, 26'h3FF0000);
        send_item(ACT_ALLOC, '0);
    endtask

    task automatic random_items(input int items);
        int          pick;
        int          idx;
        int          n;
        int          sz;
        logic        act;
        logic [25:0] off;
        for (int k = 0; k < items; k++) begin
            if (k == items / 2) wait_idle();
            n    = sb.eff_count();
            sz   = sb.size_reg;
            off  = 26'($urandom);
            act  = ACT_FREE;
            pick = $urandom_range(99);
            if (pick < 45) begin
                act = ACT_ALLOC;
            end else if (pick < 80) begin
                if (sb.handed_out.size() != 0) begin
                    idx = $urandom_range(sb.handed_out.size() - 1);
                    off = sb.handed_out[idx];
                    sb.handed_out.delete(idx);
                end else begin
                    act = ACT_ALLOC;
                end
            end else begin
                case ($urandom_range(4))
                    0: ;
                    1: off = 26'(longint'($urandom_range(n > 0 ? n - 1 : 0)) * sz
                                 + (sz > 1 ? $urandom_range(sz - 1, 1) : 1));
                    2: off = 26'(longint'(n + $urandom_range(3)) * sz);
                    3: off = 26'(longint'($urandom_range(n > 0 ? n - 1 : 0)) * sz);
                    default: off = $urandom_range(1) ? '1 : '0;
                endcase
            end
            send_item(act, off);
        end
    endtask

    initial begin
        int unsigned counts [10] = '{8, 1024, 4, 16, 1, 2047, 0, 6, 3, 17'h10805};
        int unsigned sizes  [10] = '{3, 256, 65536, 65535, 1, 1, 7, 0, 131071, 9};
        int          lengths[10] = '{200, 250, 200, 200, 150, 150, 100, 100, 150, 150};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(0);
        directed_items();
        for (int p = 0; p < 10; p++) begin
            set_config(counts[p][16:0], sizes[p][16:0], p == 5);
            set_idling(p % 4);
            random_items(lengths[p]);
        end
        wait_idle();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
